@@ hw/rtl/dhcpx_pkg.sv @@
// ============================================================================
// dhcpx_pkg
// Shared types and constants for the DHCP reply option extractor: the byte
// classes passed from front to back, option walk phases and verdict codes.
// ============================================================================
package dhcpx_pkg;

    // Option window length in bytes (4 .. 255)
    localparam int OPTION_WINDOW = 64;

    localparam logic [8:0]  WINDOW_START  = 9'd240;
    localparam logic [8:0]  WINDOW_END    = 9'(240 + OPTION_WINDOW);
    localparam logic [8:0]  MIN_LENGTH    = 9'd244;
    localparam logic [8:0]  OFFSET_MAX    = 9'd511;
    localparam logic [31:0] COOKIE_WORD   = 32'h6382_5363;
    localparam logic [31:0] DEFAULT_MASK  = 32'hFFFF_FF00;
    localparam logic [31:0] RESET_XID     = 32'hD8C7_B6A5;
    localparam logic [7:0]  RESET_TYPE    = 8'd2;
    localparam logic [7:0]  OP_REPLY      = 8'd2;

    // Option codes
    localparam logic [7:0] OPT_PAD    = 8'd0;
    localparam logic [7:0] OPT_MASK   = 8'd1;
    localparam logic [7:0] OPT_ROUTER = 8'd3;
    localparam logic [7:0] OPT_DNS    = 8'd6;
    localparam logic [7:0] OPT_TYPE   = 8'd53;
    localparam logic [7:0] OPT_SERVER = 8'd54;
    localparam logic [7:0] OPT_END    = 8'd255;

    // Front-to-back queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_XID  = 1'b0,
        CFG_TYPE = 1'b1
    } cfg_index_t;

    // Class of one payload byte, by its offset
    typedef enum logic [2:0] {
        BK_SKIP,
        BK_OP,
        BK_XID,
        BK_OFFER,
        BK_COOKIE,
        BK_WINDOW
    } byte_kind_t;

    // Option walk phase
    typedef enum logic [1:0] {
        PH_CODE,
        PH_LEN,
        PH_VALUE,
        PH_DONE
    } phase_t;

    // Verdict codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NOT_REPLY = 3'd2,
        ST_XID       = 3'd3,
        ST_COOKIE    = 3'd4
    } status_t;

    // Classified byte word handed from front to back
    typedef struct packed {
        byte_kind_t  kind;
        logic        fail;      // header check failed on this byte
        logic [7:0]  data;
        logic        last;
        logic        short_pkt; // packet ends short of the minimum length
    } item_t;

endpackage

@@ hw/rtl/dhcp_reply_option_extractor.sv @@
// ============================================================================
// dhcp_reply_option_extractor
// Parses a received DHCP reply one byte per cycle while in_stall is low and gives
// one verdict with the offered address and the kept options at the last byte.
// ============================================================================
// Throughput: one byte per cycle while in_stall is low.
// Path: the last byte goes through the front-to-back queue, and its verdict is
//   then loaded into the output register.
// Reset: clears all packet state, the queue pointers and count and out_valid, and
//   sets transaction_id and expected_type to their defaults.
module dhcp_reply_option_extractor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  message_type,
    output logic        type_matches,
    output logic [31:0] offered_ip,
    output logic [31:0] server_id,
    output logic [31:0] subnet_mask,
    output logic [31:0] router_ip,
    output logic [31:0] dns_ip,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import dhcpx_pkg::*;

    logic [31:0] xid_reg;
    logic [7:0]  etype_reg;
    logic        push_valid;
    logic        push_full;
    item_t       push_item;
    logic        pop_valid;
    logic        pop_take;
    item_t       pop_item;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xid_reg   <= RESET_XID;
            etype_reg <= RESET_TYPE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_XID:  xid_reg   <= cfg_data;
                CFG_TYPE: etype_reg <= cfg_data[7:0];
                default:  xid_reg   <= xid_reg;
            endcase
        end
    end

    dhcpx_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .transaction_id (xid_reg),
        .push_valid     (push_valid),
        .push_full      (push_full),
        .push_item      (push_item)
    );

    dhcpx_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_take   (pop_take),
        .pop_item   (pop_item)
    );

    dhcpx_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_take      (pop_take),
        .pop_item      (pop_item),
        .expected_type (etype_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .message_type  (message_type),
        .type_matches  (type_matches),
        .offered_ip    (offered_ip),
        .server_id     (server_id),
        .subnet_mask   (subnet_mask),
        .router_ip     (router_ip),
        .dns_ip        (dns_ip)
    );

endmodule

@@ hw/rtl/dhcpx_front.sv @@
// ============================================================================
// dhcpx_front
// Accepts payload bytes, tracks the byte offset, classifies each byte and
// runs the per-byte header compares before handing it to the queue.
// ============================================================================
module dhcpx_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic [31:0]          transaction_id,
    output logic                 push_valid,
    input  logic                 push_full,
    output dhcpx_pkg::item_t     push_item
);
    import dhcpx_pkg::*;

    logic [8:0] offset_reg;
    logic [8:0] offset_next;
    logic [8:0] offset_after;
    logic       take;
    logic [7:0] xid_byte;
    logic [7:0] cookie_byte;

    assign in_stall   = push_full;
    assign take       = in_valid && !push_full;
    assign push_valid = take;

    // Advance the offset, saturating at the top, and restart it at zero after the last byte
    assign offset_after = (offset_reg >= OFFSET_MAX) ? OFFSET_MAX : offset_reg + 9'd1;
    assign offset_next  = last_byte ? 9'd0 : offset_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (take)
        begin
            offset_reg <= offset_next;
        end
    end

    // Pick the expected header byte, most significant first
    always_comb
    begin
        case (offset_reg[1:0])
            2'd0:    begin xid_byte = transaction_id[31:24]; cookie_byte = COOKIE_WORD[31:24]; end
            2'd1:    begin xid_byte = transaction_id[23:16]; cookie_byte = COOKIE_WORD[23:16]; end
            2'd2:    begin xid_byte = transaction_id[15:8];  cookie_byte = COOKIE_WORD[15:8];  end
            default: begin xid_byte = transaction_id[7:0];   cookie_byte = COOKIE_WORD[7:0];   end
        endcase
    end

    // Classify the byte by its offset
    always_comb
    begin
        push_item.data      = data_byte;
        push_item.last      = last_byte;
        push_item.short_pkt = offset_after < MIN_LENGTH;
        push_item.kind      = BK_SKIP;
        push_item.fail      = 1'b0;
        if (offset_reg >= OFFSET_MAX)
        begin
            push_item.kind = BK_SKIP;
        end
        else if (offset_reg == 9'd0)
        begin
            push_item.kind = BK_OP;
            push_item.fail = data_byte != OP_REPLY;
        end
        else if (offset_reg inside {[9'd4:9'd7]})
        begin
            push_item.kind = BK_XID;
            push_item.fail = data_byte != xid_byte;
        end
        else if (offset_reg inside {[9'd16:9'd19]})
        begin
            push_item.kind = BK_OFFER;
        end
        else if (offset_reg inside {[9'd236:9'd239]})
        begin
            push_item.kind = BK_COOKIE;
            push_item.fail = data_byte != cookie_byte;
        end
        else if (offset_reg >= WINDOW_START && offset_reg < WINDOW_END)
        begin
            push_item.kind = BK_WINDOW;
        end
    end

endmodule

@@ hw/rtl/dhcpx_queue.sv @@
// ============================================================================
// dhcpx_queue
// Short register queue of classified byte words between front and back.
// ============================================================================
module dhcpx_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_full,
    input  dhcpx_pkg::item_t     push_item,
    output logic                 pop_valid,
    input  logic                 pop_take,
    output dhcpx_pkg::item_t     pop_item
);
    import dhcpx_pkg::*;

    item_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_full = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign do_push   = push_valid && !push_full;
    assign do_pop    = pop_take && pop_valid;

    // Hold words
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ hw/rtl/dhcpx_back.sv @@
// ============================================================================
// dhcpx_back
// Applies classified bytes: header flags, offered address, option walk and
// option capture. On the last byte it loads the verdict into the output
// register and clears the packet state.
// ============================================================================
module dhcpx_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_take,
    input  dhcpx_pkg::item_t     pop_item,
    input  logic [7:0]           expected_type,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [7:0]           message_type,
    output logic                 type_matches,
    output logic [31:0]          offered_ip,
    output logic [31:0]          server_id,
    output logic [31:0]          subnet_mask,
    output logic [31:0]          router_ip,
    output logic [31:0]          dns_ip
);
    import dhcpx_pkg::*;

    // Replace the leading n bytes of a word with those of a new value
    function automatic logic [31:0] merge_bytes(input logic [31:0] old_word,
                                                input logic [31:0] new_word,
                                                input logic [2:0]  n);
        logic [31:0] res;
        res = old_word;
        for (int k = 0; k < 4; k++)
        begin
            if (3'(k) < n)
            begin
                res[31-8*k -: 8] = new_word[31-8*k -: 8];
            end
        end
        return res;
    endfunction

    // Packet state
    logic [2:0]  flags_reg,  flags_next;
    phase_t      phase_reg,  phase_next;
    logic [7:0]  code_reg,   code_next;
    logic [7:0]  left_reg,   left_next;
    logic [7:0]  idx_reg,    idx_next;
    logic [31:0] pend_reg,   pend_next;
    logic [4:0]  found_reg,  found_next;
    logic [31:0] offer_reg,  offer_next;
    logic [7:0]  type_reg,   type_next;
    logic [31:0] server_reg, server_next;
    logic [31:0] mask_reg,   mask_next;
    logic [31:0] router_reg, router_next;
    logic [31:0] dns_reg,    dns_next;

    // Output register
    logic        out_valid_reg;
    status_t     status_reg;
    logic [7:0]  mtype_reg;
    logic        match_reg;
    logic [31:0] o_offer_reg;
    logic [31:0] o_server_reg;
    logic [31:0] o_mask_reg;
    logic [31:0] o_router_reg;
    logic [31:0] o_dns_reg;

    logic        commit_en;
    logic [7:0]  commit_idx;
    logic [31:0] commit_pend;
    logic [2:0]  commit_n;
    logic [2:0]  flags_new;
    status_t     verdict;
    logic        take;
    logic        load_out;
    logic        is_window;

    // Take a word unless a result would overrun a held output
    assign take     = pop_valid && (!pop_item.last || !out_valid_reg || !out_stall);
    assign pop_take = take;
    assign load_out = take && pop_item.last;
    assign is_window = pop_item.kind == BK_WINDOW;

    // Header flags
    always_comb
    begin
        flags_new = flags_reg;
        if (pop_item.fail)
        begin
            case (pop_item.kind)
                BK_OP:     flags_new[0] = 1'b1;
                BK_XID:    flags_new[1] = 1'b1;
                BK_COOKIE: flags_new[2] = 1'b1;
                default:   flags_new = flags_reg;
            endcase
        end
    end

    // Option walk
    always_comb
    begin
        phase_next  = phase_reg;
        code_next   = code_reg;
        left_next   = left_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        commit_en   = 1'b0;
        commit_idx  = idx_reg;
        commit_pend = pend_reg;
        if (is_window)
        begin
            case (phase_reg)
                PH_CODE:
                begin
                    if (pop_item.data == OPT_END)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (pop_item.data != OPT_PAD)
                    begin
                        code_next  = pop_item.data;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    left_next   = pop_item.data;
                    idx_next    = '0;
                    pend_next   = '0;
                    commit_idx  = '0;
                    commit_pend = '0;
                    if (pop_item.data == 8'd0)
                    begin
                        commit_en  = 1'b1;
                        phase_next = PH_CODE;
                    end
                    else
                    begin
                        phase_next = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    case (idx_reg)
                        8'd0:    pend_next = pend_reg | {pop_item.data, 24'd0};
                        8'd1:    pend_next = pend_reg | {8'd0, pop_item.data, 16'd0};
                        8'd2:    pend_next = pend_reg | {16'd0, pop_item.data, 8'd0};
                        8'd3:    pend_next = pend_reg | {24'd0, pop_item.data};
                        default: pend_next = pend_reg;
                    endcase
                    idx_next    = idx_reg + 8'd1;
                    left_next   = left_reg - 8'd1;
                    commit_idx  = idx_next;
                    commit_pend = pend_next;
                    if (left_reg == 8'd1)
                    begin
                        commit_en  = 1'b1;
                        phase_next = PH_CODE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Store the first occurrence of each kept option
    assign commit_n = (commit_idx >= 8'd4) ? 3'd4 : commit_idx[2:0];

    always_comb
    begin
        found_next  = found_reg;
        type_next   = type_reg;
        server_next = server_reg;
        mask_next   = mask_reg;
        router_next = router_reg;
        dns_next    = dns_reg;
        if (commit_en)
        begin
            case (code_reg)
                OPT_TYPE:
                begin
                    if (!found_reg[0])
                    begin
                        found_next[0] = 1'b1;
                        if (commit_n != 3'd0)
                        begin
                            type_next = commit_pend[31:24];
                        end
                    end
                end
                OPT_SERVER:
                begin
                    if (!found_reg[1])
                    begin
                        found_next[1] = 1'b1;
                        server_next   = merge_bytes(server_reg, commit_pend, commit_n);
                    end
                end
                OPT_MASK:
                begin
                    if (!found_reg[2])
                    begin
                        found_next[2] = 1'b1;
                        mask_next     = merge_bytes(mask_reg, commit_pend, commit_n);
                    end
                end
                OPT_ROUTER:
                begin
                    if (!found_reg[3])
                    begin
                        found_next[3] = 1'b1;
                        router_next   = merge_bytes(router_reg, commit_pend, commit_n);
                    end
                end
                OPT_DNS:
                begin
                    if (!found_reg[4])
                    begin
                        found_next[4] = 1'b1;
                        dns_next      = merge_bytes(dns_reg, commit_pend, commit_n);
                    end
                end
                default:
                begin
                    found_next = found_reg;
                end
            endcase
        end
    end

    // Shift in the offered address
    assign offer_next = (pop_item.kind == BK_OFFER) ? {offer_reg[23:0], pop_item.data}
                                                    : offer_reg;
    assign flags_next = flags_new;

    // Verdict in priority order
    always_comb
    begin
        if (pop_item.short_pkt)
        begin
            verdict = ST_SHORT;
        end
        else if (flags_new[0])
        begin
            verdict = ST_NOT_REPLY;
        end
        else if (flags_new[1])
        begin
            verdict = ST_XID;
        end
        else if (flags_new[2])
        begin
            verdict = ST_COOKIE;
        end
        else
        begin
            verdict = ST_OK;
        end
    end

    // Update packet state; clear it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg  <= '0;
            phase_reg  <= PH_CODE;
            code_reg   <= '0;
            left_reg   <= '0;
            idx_reg    <= '0;
            pend_reg   <= '0;
            found_reg  <= '0;
            offer_reg  <= '0;
            type_reg   <= '0;
            server_reg <= '0;
            mask_reg   <= DEFAULT_MASK;
            router_reg <= '0;
            dns_reg    <= '0;
        end
        else if (take)
        begin
            if (pop_item.last)
            begin
                flags_reg  <= '0;
                phase_reg  <= PH_CODE;
                code_reg   <= '0;
                left_reg   <= '0;
                idx_reg    <= '0;
                pend_reg   <= '0;
                found_reg  <= '0;
                offer_reg  <= '0;
                type_reg   <= '0;
                server_reg <= '0;
                mask_reg   <= DEFAULT_MASK;
                router_reg <= '0;
                dns_reg    <= '0;
            end
            else
            begin
                flags_reg  <= flags_next;
                phase_reg  <= phase_next;
                code_reg   <= code_next;
                left_reg   <= left_next;
                idx_reg    <= idx_next;
                pend_reg   <= pend_next;
                found_reg  <= found_next;
                offer_reg  <= offer_next;
                type_reg   <= type_next;
                server_reg <= server_next;
                mask_reg   <= mask_next;
                router_reg <= router_next;
                dns_reg    <= dns_next;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load result fields; zero them on a rejected packet
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg <= verdict;
            if (verdict == ST_OK)
            begin
                mtype_reg    <= type_next;
                match_reg    <= type_next == expected_type;
                o_offer_reg  <= offer_next;
                o_server_reg <= server_next;
                o_mask_reg   <= mask_next;
                o_router_reg <= router_next;
                o_dns_reg    <= dns_next;
            end
            else
            begin
                mtype_reg    <= '0;
                match_reg    <= 1'b0;
                o_offer_reg  <= '0;
                o_server_reg <= '0;
                o_mask_reg   <= '0;
                o_router_reg <= '0;
                o_dns_reg    <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign message_type = mtype_reg;
    assign type_matches = match_reg;
    assign offered_ip   = o_offer_reg;
    assign server_id    = o_server_reg;
    assign subnet_mask  = o_mask_reg;
    assign router_ip    = o_router_reg;
    assign dns_ip       = o_dns_reg;

endmodule
